// File: rtl/pat_pkg.sv
`default_nettype none

package pat_pkg;

  // Fixed field widths of the stream payloads
  localparam int VA_W  = 16;  // virtual address
  localparam int PA_W  = 15;  // physical address
  localparam int EP_W  = 8;   // evicted page number
  localparam int FC_W  = 16;  // fault total
  localparam int AGE_W = 32;  // per-page age

  localparam int OUT_DATA_W = 40;  // PA_W + EP_W + FC_W, padded to whole bytes

endpackage

`default_nettype wire

// File: rtl/pat_ram.sv
`default_nettype none

module pat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/pat_cdiv.sv
`default_nettype none

// Division by a fixed divisor through a reciprocal multiply.
// Quotient and remainder are valid with done, after the product and quotient registers.
module pat_cdiv #(
  parameter int DIVISOR = 256
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [pat_pkg::VA_W-1:0] dividend,
  output logic                          done,
  output logic      [pat_pkg::VA_W-1:0] quotient,
  output logic      [pat_pkg::VA_W-1:0] remainder
);

  import pat_pkg::*;

  // q = (n * ceil(2^SH / d)) >> SH is exact for every n below 2^VA_W
  localparam int     SH     = VA_W + $clog2(DIVISOR);
  localparam int     RCP_W  = VA_W + 1;
  localparam int     PROD_W = VA_W + RCP_W;
  localparam longint RCP_L  = ((longint'(1) << SH) + longint'(DIVISOR - 1)) / longint'(DIVISOR);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);
  localparam logic [VA_W:0]    DV  = (VA_W + 1)'(DIVISOR);

  logic [1:0]        stage;
  logic [PROD_W-1:0] prod;
  logic [VA_W-1:0]   dvd;
  logic [VA_W-1:0]   qd;

  assign qd = VA_W'(PROD_W'(quotient) * PROD_W'(DV));

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[0], start};
      done  <= stage[1];
      if (start) begin
        prod <= PROD_W'(dividend) * PROD_W'(RCP);
        dvd  <= dividend;
      end
      if (stage[0]) begin
        quotient <= VA_W'(prod >> SH);
      end
      if (stage[1]) begin
        remainder <= dvd - qd;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/paged_address_translator_fifo.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: virtual_address
// m_*       out  m_tvalid/m_tready  m_tdata: physical_address, evicted_page, fault_total
//                                   m_tuser: page_fault
//
// One request at a time: page/offset split by two reciprocal-multiply divides
// in turn, then a sweep of the page table RAM at one entry per cycle, then the
// victim and faulting-page write-backs (S_FIX_VIC, S_FIX_PAGE) on a fault, then
// S_RESULT loads the output register once it is empty or m_tready is high.
// After rst a clearing pass over every entry loads the reset page table;
// s_tready stays low during it. A result waiting in the output register does
// not block the next request; only loading the next result waits on m_tready.

module paged_address_translator_fifo #(
  parameter int NUM_PAGES  = 256,
  parameter int NUM_FRAMES = 128,
  parameter int PAGE_BYTES = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [pat_pkg::VA_W-1:0]       s_tdata,   // [15:0] virtual_address
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [pat_pkg::OUT_DATA_W-1:0] m_tdata,   // [14:0] physical_address,
                                                         // [22:15] evicted_page,
                                                         // [38:23] fault_total, [39] zero
  output logic                                m_tuser    // [0] page_fault
);

  import pat_pkg::*;

  localparam int PG_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int FW     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int OFFS_W = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int WORD_W = 1 + FW + AGE_W;
  localparam int CMP_W  = ((PG_W > FW) ? PG_W : FW) + 1;
  localparam int PX_W   = ((FW + OFFS_W + 1) > PA_W) ? (FW + OFFS_W + 1) : PA_W;
  localparam int EX_W   = (PG_W > EP_W) ? PG_W : EP_W;
  localparam logic [PG_W-1:0] LAST_PAGE = PG_W'(NUM_PAGES - 1);

  typedef struct packed {
    logic             valid;
    logic [FW-1:0]    frame;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIVIDE, S_MODULO, S_SWEEP, S_FIX_VIC, S_FIX_PAGE, S_RESULT
  } state_t;

  state_t state;

  // Address split: va / PAGE_BYTES, then page number modulo NUM_PAGES
  logic             div_done, mod_done;
  logic [VA_W-1:0]  div_quo, div_rem, mod_quo, mod_rem;
  logic             accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  pat_cdiv #(.DIVISOR(PAGE_BYTES)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (s_tdata),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  pat_cdiv #(.DIVISOR(NUM_PAGES)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_done),
    .dividend (div_quo),
    .done     (mod_done),
    .quotient (mod_quo),
    .remainder(mod_rem)
  );

  // Request context
  logic [OFFS_W-1:0] offset;
  logic [PG_W-1:0]   page;
  logic [FC_W-1:0]   fault_count;

  // Sweep control and scan results
  logic [PG_W-1:0]   idx;       // read address / clear address
  logic              rd_active;
  logic              pend;      // read data for pidx is on the RAM output
  logic [PG_W-1:0]   pidx;
  logic              cap_valid;
  logic [FW-1:0]     cap_frame;
  logic              found;
  logic [AGE_W-1:0]  best;
  logic [PG_W-1:0]   victim;
  logic [FW-1:0]     vframe;

  // RAM ports
  logic              we;
  logic [PG_W-1:0]   waddr;
  entry_t            wdata;
  entry_t            rdata;
  logic [WORD_W-1:0] rdata_raw;

  assign rdata = entry_t'(rdata_raw);

  pat_ram #(.WIDTH(WORD_W), .DEPTH(NUM_PAGES)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(WORD_W'(wdata)),
    .raddr(idx),
    .rdata(rdata_raw)
  );

  // Reset image of one entry
  logic [CMP_W-1:0] clr_ix;
  logic             init_valid;
  entry_t           init_entry;

  assign clr_ix     = CMP_W'(idx);
  assign init_valid = clr_ix < CMP_W'(NUM_FRAMES);

  always_comb begin
    init_entry.valid = init_valid;
    init_entry.frame = init_valid ? FW'(idx) : '0;
    init_entry.age   = init_valid ? (AGE_W'(NUM_FRAMES) - AGE_W'(idx)) : '0;
  end

  // Fault outcome
  logic          fault;
  logic [FW-1:0] new_frame;
  logic [FW-1:0] res_frame;

  assign fault     = !cap_valid;
  assign new_frame = found ? vframe : '0;
  assign res_frame = fault ? new_frame : cap_frame;

  // Write port: clear pass, age write-back, victim and faulting-page updates
  always_comb begin
    we    = 1'b0;
    waddr = pidx;
    wdata = rdata;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = idx;
        wdata = init_entry;
      end
      S_SWEEP: begin
        we        = pend;
        waddr     = pidx;
        wdata     = rdata;
        wdata.age = (&rdata.age) ? rdata.age : rdata.age + 1'b1;
      end
      S_FIX_VIC: begin
        we          = found;
        waddr       = victim;
        wdata.valid = 1'b0;
        wdata.frame = '0;
        wdata.age   = AGE_W'(1);   // cleared, then aged once
      end
      S_FIX_PAGE: begin
        we          = 1'b1;
        waddr       = page;
        wdata.valid = 1'b1;
        wdata.frame = new_frame;
        wdata.age   = AGE_W'(1);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Result formatting
  logic [PX_W-1:0] phys_full;
  logic [EX_W-1:0] ev_full;
  logic [FC_W-1:0] fault_count_next;

  assign phys_full = PX_W'(res_frame) * PX_W'(PAGE_BYTES) + PX_W'(offset);
  assign ev_full   = fault ? EX_W'(victim) : '0;
  assign fault_count_next = (fault && !(&fault_count)) ? fault_count + 1'b1 : fault_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      idx         <= '0;
      rd_active   <= 1'b0;
      pend        <= 1'b0;
      fault_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // S_RESULT handles its own handshake when it reloads the register
      if (m_tvalid && m_tready && state != S_RESULT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (idx == LAST_PAGE) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            offset <= div_rem[OFFS_W-1:0];
            state  <= S_MODULO;
          end
        end
        S_MODULO: begin
          if (mod_done) begin
            page      <= mod_rem[PG_W-1:0];
            idx       <= '0;
            rd_active <= 1'b1;
            pend      <= 1'b0;
            found     <= 1'b0;
            best      <= '0;
            victim    <= '0;
            vframe    <= '0;
            cap_valid <= 1'b0;
            cap_frame <= '0;
            state     <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          pend <= rd_active;
          pidx <= idx;
          if (rd_active) begin
            if (idx == LAST_PAGE) begin
              rd_active <= 1'b0;
            end else begin
              idx <= idx + 1'b1;
            end
          end
          if (pend) begin
            if (pidx == page) begin
              cap_valid <= rdata.valid;
              cap_frame <= rdata.frame;
            end
            // oldest mapped page, first one wins ties; compared before aging
            if (rdata.valid && (!found || rdata.age > best)) begin
              found  <= 1'b1;
              best   <= rdata.age;
              victim <= pidx;
              vframe <= rdata.frame;
            end
          end
          if (!rd_active && !pend) begin
            idx   <= '0;
            state <= fault ? S_FIX_VIC : S_RESULT;
          end
        end
        S_FIX_VIC: begin
          state <= S_FIX_PAGE;
        end
        S_FIX_PAGE: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            m_tdata     <= {1'b0, fault_count_next, ev_full[EP_W-1:0], phys_full[PA_W-1:0]};
            m_tuser     <= fault;
            fault_count <= fault_count_next;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  import pat_pkg::*;

  localparam int NUM_PAGES  = 256;
  localparam int NUM_FRAMES = 128;
  localparam int PAGE_BYTES = 256;

  localparam int N_DIRECTED   = 20;
  localparam int N_RANDOM     = 800;
  localparam int HOLD_CYCLES  = 3000;   // long receiver hold-off
  localparam int IDLE_LIMIT   = 20000;  // watchdog: cycles with no handshake on either side
  localparam int TAIL_CYCLES  = 400;    // idle tail after the last result
  localparam int HOLD_AT      = 300;    // random request index that starts the hold-off
  localparam int HOLD_BURST   = 16;     // back-to-back requests offered during the hold-off
  localparam int DRAIN_AT     = 520;    // random request index where the sender drains

  // One translated request as seen on the master side
  typedef struct packed {
    logic [PA_W-1:0] phys;
    logic            fault;
    logic [EP_W-1:0] evicted;
    logic [FC_W-1:0] total;
  } xlat_result_t;

  typedef struct packed {
    logic [VA_W-1:0] va;
    logic            typed;  // 1: compare against 'want' below, not the predictor
    xlat_result_t    want;
  } stim_row_t;

  // Directed requests. Typed rows follow from the reset page table:
  // pages 0..127 map frames 0..127, oldest is page 0, then page 1.
  localparam stim_row_t DIR_ROWS [N_DIRECTED] = '{
    '{16'h0000, 1'b1, '{15'h0000, 1'b0, 8'd0, 16'd0}},  // hit, lowest address
    '{16'hFFFF, 1'b1, '{15'h00FF, 1'b1, 8'd0, 16'd1}},  // top page faults, page 0 loses frame 0
    '{16'h7FFF, 1'b1, '{15'h7FFF, 1'b0, 8'd0, 16'd1}},  // last mapped page, widest result
    '{16'h8000, 1'b1, '{15'h0100, 1'b1, 8'd1, 16'd2}},  // first unmapped page takes frame 1
    '{16'hFF00, 1'b0, '0},  // page 255 now mapped
    '{16'h0080, 1'b0, '0},  // page 0 was evicted -> fault
    '{16'h5555, 1'b0, '0},
    '{16'hAAAA, 1'b0, '0},
    '{16'h00FF, 1'b0, '0},
    '{16'h0100, 1'b0, '0},  // page 1 evicted earlier
    '{16'h8001, 1'b0, '0},
    '{16'h7F00, 1'b0, '0},
    '{16'h1234, 1'b0, '0},
    '{16'hEDCB, 1'b0, '0},
    '{16'hC3C3, 1'b0, '0},
    '{16'h3C3C, 1'b0, '0},
    '{16'h8181, 1'b0, '0},
    '{16'h7E7E, 1'b0, '0},
    '{16'h0001, 1'b0, '0},
    '{16'hFFFE, 1'b0, '0}
  };

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [VA_W-1:0]       s_tdata  = '0;      // [15:0] virtual_address
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;            // [14:0] phys, [22:15] evicted, [38:23] total
  logic                  m_tuser;            // [0] page_fault

  always #2 clk = ~clk;

  paged_address_translator_fifo #(
    .NUM_PAGES (NUM_PAGES),
    .NUM_FRAMES(NUM_FRAMES),
    .PAGE_BYTES(PAGE_BYTES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // ---------------------------------------------------------------------------
  // Page table shadow: frame, valid bit and age per page, plus fault count
  // ---------------------------------------------------------------------------
  logic [6:0]      pt_frame [NUM_PAGES];
  logic            pt_valid [NUM_PAGES];
  logic [AGE_W-1:0] pt_age  [NUM_PAGES];
  logic [FC_W-1:0] fault_count;

  xlat_result_t pending_xlat [$];  // translations owed by the block, oldest first

  int n_errors   = 0;
  int n_results  = 0;
  int n_requests = 0;
  int n_faults   = 0;
  bit hold_out   = 1'b0;  // sender asks the receiver for the long hold-off

  task automatic load_reset_table();
    for (int i = 0; i < NUM_PAGES; i++) begin
      pt_valid[i] = (i < NUM_FRAMES);
      pt_frame[i] = (i < NUM_FRAMES) ? 7'(i) : 7'd0;
      pt_age[i]   = (i < NUM_FRAMES) ? AGE_W'(NUM_FRAMES - i) : '0;
    end
    fault_count = '0;
  endtask

  // Translate one virtual address and advance the shadow table.
  // On a miss the mapped page with the largest age (lowest index on ties)
  // gives up its frame; unmapped pages are never victims.
  function automatic xlat_result_t translate_address(input logic [VA_W-1:0] va);
    xlat_result_t     res;
    logic [7:0]       page;
    logic [7:0]       victim;
    logic [AGE_W-1:0] oldest;
    logic [6:0]       frame;
    bit               found;
    page   = va[15:8];
    res    = '0;
    found  = 1'b0;
    oldest = '0;
    victim = '0;
    frame  = '0;
    if (!pt_valid[page]) begin
      res.fault = 1'b1;
      if (fault_count != '1) fault_count++;
      for (int i = 0; i < NUM_PAGES; i++) begin
        if (pt_valid[i] && (!found || pt_age[i] > oldest)) begin
          found  = 1'b1;
          oldest = pt_age[i];
          victim = 8'(i);
        end
      end
      // with nothing mapped the faulting page takes frame 0, evicted reads 0
      if (found) begin
        frame            = pt_frame[victim];
        pt_valid[victim] = 1'b0;
        pt_frame[victim] = '0;
        pt_age[victim]   = '0;
        res.evicted      = victim;
      end
      pt_frame[page] = frame;
      pt_valid[page] = 1'b1;
      pt_age[page]   = '0;
    end
    res.phys  = {pt_frame[page], va[7:0]};
    res.total = fault_count;
    for (int i = 0; i < NUM_PAGES; i++)
      if (pt_age[i] != '1) pt_age[i]++;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(4, 1);
    if (r < 97) return $urandom_range(40, 5);
    return $urandom_range(600, 100);
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH t=%0t result #%0d %s: got 0x%0h, want 0x%0h",
             $time, n_results, what, got, want);
    n_errors++;
  endtask

  // Offer one request after 'gap' idle cycles; record the expected
  // translation at the edge where it is taken.
  task automatic send_request(input logic [VA_W-1:0] va, input logic typed,
                              input xlat_result_t want, input int gap);
    xlat_result_t pred;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= va;
    do @(posedge clk); while (s_tready !== 1'b1);
    pred = translate_address(va);
    if (pred.fault) n_faults++;
    pending_xlat.push_back(typed ? want : pred);
    n_requests++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    xlat_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending_xlat.size() == 0) begin
        flag_mismatch("result with no request pending", m_tdata, 0);
      end else begin
        want = pending_xlat.pop_front();
        if (m_tdata[14:0] !== want.phys)
          flag_mismatch("physical_address", m_tdata[14:0], want.phys);
        if (m_tuser !== want.fault)
          flag_mismatch("page_fault", m_tuser, want.fault);
        if (m_tdata[22:15] !== want.evicted)
          flag_mismatch("evicted_page", m_tdata[22:15], want.evicted);
        if (m_tdata[38:23] !== want.total)
          flag_mismatch("fault_total", m_tdata[38:23], want.total);
      end
      n_results++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready bursts and gaps, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_out) begin
        // block keeps one result and one request in flight, then stalls s_tready
        hold_out = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(20, 1)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run if no request or result moves for too long
  // ---------------------------------------------------------------------------
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
        idle = 0;
      else
        idle++;
    end
    $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]      page;
    logic [VA_W-1:0] va;
    logic [7:0]      recent [$];
    int              r;
    int              gap;

    load_reset_table();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < N_DIRECTED; n++)
      send_request(DIR_ROWS[n].va, DIR_ROWS[n].typed, DIR_ROWS[n].want, pick_gap());

    // Random part: a mix of recently touched pages (mostly hits), pages from
    // the initially mapped half, and any page at all (about half faults).
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(99);
      if (r < 40 && recent.size() > 0)
        page = recent[$urandom_range(recent.size() - 1)];
      else if (r < 60)
        page = 8'($urandom_range(NUM_FRAMES - 1));
      else
        page = 8'($urandom_range(NUM_PAGES - 1));
      va = {page, 8'($urandom)};
      recent.push_back(page);
      if (recent.size() > 16) void'(recent.pop_front());

      if (n == HOLD_AT) hold_out = 1'b1;
      if (n == DRAIN_AT) begin
        // sender pauses until every translation has come back
        s_tvalid <= 1'b0;
        while (pending_xlat.size() != 0) @(posedge clk);
        gap = 0;
      end else if (n >= HOLD_AT && n < HOLD_AT + HOLD_BURST) begin
        gap = 0;  // keep offering during the hold-off
      end else begin
        gap = pick_gap();
      end
      send_request(va, 1'b0, '0, gap);
    end
    s_tvalid <= 1'b0;

    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d directed, %0d random): %0d page faults, %0d hits.",
             n_requests, N_DIRECTED, N_RANDOM, n_faults, n_requests - n_faults);
    $display("Included a %0d-cycle receiver hold-off with input back-pressure and a full drain.",
             HOLD_CYCLES);
    if (n_errors == 0 && pending_xlat.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pat_pkg.sv
rtl/pat_ram.sv
rtl/pat_cdiv.sv
rtl/paged_address_translator_fifo.sv
test/tb_top.sv
